// ===== rtl/brfs_pkg.sv =====
// ----------------------------------------------------------------------------
// brfs_pkg
// Shared types and constants of the byte ring FIFO with search.
// ----------------------------------------------------------------------------
`default_nettype none

package brfs_pkg;

  localparam int unsigned BYTE_W = 8;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_FIND = 2'd2
  } req_t;

endpackage

`default_nettype wire

// ===== rtl/brfs_ram.sv =====
// ----------------------------------------------------------------------------
// brfs_ram
// Byte store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brfs_ram
  import brfs_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire byte_t                    wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output byte_t                         rd_data_r
);

  byte_t mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/byte_ring_fifo_with_search.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_search
// Ring-buffer FIFO of bytes with enqueue, dequeue and search requests.
//
// Channel  Dir  Word layout (lowest bit first)
// in_      in   tdata: data_in[7:0]     tuser: req_type[1:0]
// out_     out  tdata: data_out[7:0]    tuser: ok, is_empty, is_full
//
// Enqueue, unused codes and a dequeue or search on an empty ring go straight
// to the response step; a dequeue with data first waits for the store read.
// Search compares held bytes from the oldest on, up to DEPTH-1 of them, one
// store read and one byte compare per cycle, stopping at a match or the newest.
// Reset clears both pointers; the byte store is not cleared.
// A finished result holds in the sequencer until the output register is free;
// a new word is taken while an earlier result still waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_with_search
  import brfs_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // data_in[7:0]
  input  wire logic [1:0] in_tuser,   // req_type[1:0]
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // data_out[7:0]
  output logic [2:0]      out_tuser   // ok, is_empty, is_full
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  typedef logic [AW-1:0] ptr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SCAN,
    S_RESP
  } state_t;

  function automatic ptr_t next_ptr(input ptr_t p);
    next_ptr = (p == LAST) ? '0 : p + 1'b1;
  endfunction

  state_t state_r, state_nxt;
  ptr_t   wptr_r, wptr_nxt;
  ptr_t   rptr_r, rptr_nxt;
  ptr_t   pos_r, pos_nxt;
  byte_t  key_r, key_nxt;
  byte_t  data_r, data_nxt;
  logic   ok_r, ok_nxt;
  logic   out_valid_r, out_valid_nxt;
  byte_t  out_data_r, out_data_nxt;
  logic   out_ok_r, out_ok_nxt;
  logic   out_empty_r, out_empty_nxt;
  logic   out_full_r, out_full_nxt;

  logic   accept;
  logic   is_empty_c;
  logic   is_full_c;
  logic   out_free;
  req_t   req_c;
  logic   wr_en;
  logic   rd_en;
  ptr_t   rd_addr;
  byte_t  rd_data;

  brfs_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wptr_r),
    .wr_data  (in_tdata),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data_r(rd_data)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign req_c      = req_t'(in_tuser);
  assign is_empty_c = (wptr_r == rptr_r);
  assign is_full_c  = (next_ptr(wptr_r) == rptr_r);
  assign out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_full_r, out_empty_r, out_ok_r};

  always_comb begin
    state_nxt     = state_r;
    wptr_nxt      = wptr_r;
    rptr_nxt      = rptr_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    data_nxt      = data_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_ok_nxt    = out_ok_r;
    out_empty_nxt = out_empty_r;
    out_full_nxt  = out_full_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = rptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt   = in_tdata;
          data_nxt  = '0;
          ok_nxt    = 1'b0;
          state_nxt = S_RESP;
          unique case (req_c)
            REQ_ENQ: begin
              if (!is_full_c) begin
                wr_en    = 1'b1;
                wptr_nxt = next_ptr(wptr_r);
                ok_nxt   = 1'b1;
              end
            end
            REQ_DEQ: begin
              if (!is_empty_c) begin
                rd_en     = 1'b1;
                state_nxt = S_DEQ;
              end
            end
            REQ_FIND: begin
              if (!is_empty_c) begin
                rd_en     = 1'b1;
                pos_nxt   = rptr_r;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_DEQ: begin
        data_nxt  = rd_data;
        ok_nxt    = 1'b1;
        rptr_nxt  = next_ptr(rptr_r);
        state_nxt = S_RESP;
      end
      S_SCAN: begin
        rd_addr = next_ptr(pos_r);
        if (rd_data == key_r) begin
          ok_nxt    = 1'b1;
          state_nxt = S_RESP;
        end else if (next_ptr(pos_r) == wptr_r) begin
          state_nxt = S_RESP;
        end else begin
          rd_en   = 1'b1;
          pos_nxt = next_ptr(pos_r);
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_r;
          out_ok_nxt    = ok_r;
          out_empty_nxt = is_empty_c;
          out_full_nxt  = is_full_c;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wptr_r      <= '0;
      rptr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wptr_r      <= wptr_nxt;
      rptr_r      <= rptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r       <= pos_nxt;
    key_r       <= key_nxt;
    data_r      <= data_nxt;
    ok_r        <= ok_nxt;
    out_data_r  <= out_data_nxt;
    out_ok_r    <= out_ok_nxt;
    out_empty_r <= out_empty_nxt;
    out_full_r  <= out_full_nxt;
  end

  a_not_empty_and_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(is_empty_c && is_full_c))
    else $error("fifo reports empty and full together");

  a_scan_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (pos_r != wptr_r))
    else $error("search position reached write pointer");

  a_rptr_moves_on_deq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DEQ) |=> $stable(rptr_r))
    else $error("read pointer moved outside dequeue");

  a_wptr_moves_on_enq: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && req_c == REQ_ENQ) |=> $stable(wptr_r))
    else $error("write pointer moved outside enqueue");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result loaded outside response step");

endmodule

`default_nettype wire

// ===== sim/byte_ring_fifo_with_search_tb.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_search_tb
// Self-checking bench for the byte ring FIFO with search. A queue of requests
// feeds a stream driver with random gaps. Each accepted word updates a local
// copy of the ring and its pointers, which predicts the reply. A monitor with
// random back-pressure compares every reply field with the oldest prediction.
// Traffic runs through directed corner cases, then fill, drain and mixed
// bursts that push the ring to full and back to empty many times.
// ----------------------------------------------------------------------------

module byte_ring_fifo_with_search_tb;
  import brfs_pkg::*;

  localparam int unsigned DEPTH     = 16;
  localparam int          N_ITEMS   = 1650;
  localparam int          CYC_LIMIT = 400000;
  localparam logic [1:0]  REQ_NOP   = 2'd3;

  typedef struct {
    logic [1:0] req;
    byte_t      val;
    int         gap;
    bit         hold;
  } fifo_req_t;

  typedef struct {
    byte_t data;
    logic  ok;
    logic  empty;
    logic  full;
  } fifo_reply_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;

  byte_ring_fifo_with_search #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // data_in[7:0]
    .in_tuser   (in_tuser),   // req_type[1:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // data_out[7:0]
    .out_tuser  (out_tuser)   // ok, is_empty, is_full
  );

  fifo_req_t   req_queue[$];
  fifo_reply_t reply_queue[$];

  byte_t       ring_mem [DEPTH];
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;

  int          items_sent = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int          n_enq_ok = 0, n_enq_drop = 0, n_deq_ok = 0, n_deq_empty = 0;
  int          n_find_hit = 0, n_find_miss = 0, n_nop = 0;
  int          rx_stall = 0;
  bit          rx_quiet = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  function automatic int unsigned ring_held();
    return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
  endfunction

  task automatic ring_apply(input logic [1:0] req, input byte_t val);
    fifo_reply_t r;
    int unsigned pos;
    r.data = '0;
    r.ok   = 1'b0;
    case (req)
      REQ_ENQ: begin
        if (ring_held() != DEPTH - 1) begin
          ring_mem[wr_ptr] = val;
          wr_ptr = (wr_ptr + 1) % DEPTH;
          r.ok = 1'b1;
          n_enq_ok++;
        end else begin
          n_enq_drop++;
        end
      end
      REQ_DEQ: begin
        if (wr_ptr != rd_ptr) begin
          r.data = ring_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1) % DEPTH;
          r.ok = 1'b1;
          n_deq_ok++;
        end else begin
          n_deq_empty++;
        end
      end
      REQ_FIND: begin
        pos = rd_ptr;
        while (pos != wr_ptr && !r.ok) begin
          if (ring_mem[pos] == val) r.ok = 1'b1;
          pos = (pos + 1) % DEPTH;
        end
        if (r.ok) n_find_hit++;
        else n_find_miss++;
      end
      default: n_nop++;
    endcase
    r.empty = (wr_ptr == rd_ptr);
    r.full  = (ring_held() == DEPTH - 1);
    reply_queue.push_back(r);
  endtask

  task automatic add_req(input logic [1:0] req, input byte_t val, input int gap,
                         input bit hold);
    fifo_req_t it;
    it.req  = req;
    it.val  = val;
    it.gap  = gap;
    it.hold = hold;
    req_queue.push_back(it);
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        ring_apply(in_tuser, in_tdata);
        items_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (req_queue.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (req_queue[0].gap > 0) begin
          req_queue[0].gap--;
          in_tvalid <= 1'b0;
        end else if (req_queue[0].hold && items_sent != results_seen) begin
          in_tvalid <= 1'b0;
        end else begin
          in_tuser  <= req_queue[0].req;
          in_tdata  <= req_queue[0].val;
          in_tvalid <= 1'b1;
          void'(req_queue.pop_front());
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    fifo_reply_t e;
    int nxt;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall   <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (reply_queue.size() == 0) begin
          note_mismatch($sformatf("unexpected word data=%02h user=%03b",
                                  out_tdata, out_tuser));
        end else begin
          e = reply_queue.pop_front();
          if (out_tdata !== e.data || out_tuser[0] !== e.ok ||
              out_tuser[1] !== e.empty || out_tuser[2] !== e.full)
            note_mismatch($sformatf(
              "exp data=%02h ok=%b empty=%b full=%b, got data=%02h ok=%b empty=%b full=%b",
              e.data, e.ok, e.empty, e.full,
              out_tdata, out_tuser[0], out_tuser[1], out_tuser[2]));
        end
        if (results_seen % 60 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
        nxt = rx_quiet ? 0 : $urandom_range(0, 8);
        rx_stall   <= nxt;
        out_tready <= (nxt == 0);
      end else if (!out_tready) begin
        if (rx_stall <= 1) begin
          out_tready <= 1'b1;
          rx_stall   <= 0;
        end else begin
          rx_stall <= rx_stall - 1;
        end
      end
    end
  end

  initial begin
    int    mode, len, r, gap, enq_lim, deq_lim;
    bit    quiet;
    byte_t v;

    // empty ring corner cases
    add_req(REQ_DEQ, 8'hFF, 0, 1'b0);
    add_req(REQ_FIND, 8'h00, 2, 1'b0);
    add_req(REQ_NOP, 8'hAA, 0, 1'b0);
    // fill to full, oldest 00 and newest FF
    for (int i = 0; i < DEPTH - 1; i++) begin
      v = (i == 0) ? 8'h00 : (i == DEPTH - 2) ? 8'hFF : byte_t'(8'h10 + i);
      add_req(REQ_ENQ, v, $urandom_range(0, 3), 1'b0);
    end
    add_req(REQ_ENQ, 8'h5A, 0, 1'b0);
    add_req(REQ_FIND, 8'h00, 0, 1'b1);
    add_req(REQ_FIND, 8'hFF, 1, 1'b0);
    add_req(REQ_FIND, 8'hA5, 0, 1'b0);
    add_req(REQ_NOP, 8'h55, 0, 1'b0);
    add_req(REQ_DEQ, 8'h00, 0, 1'b0);

    while (req_queue.size() < N_ITEMS) begin
      mode  = $urandom_range(0, 2);
      len   = $urandom_range(10, 40);
      quiet = ($urandom_range(0, 3) == 0);
      case (mode)
        0: begin enq_lim = 65; deq_lim = 80; end
        1: begin enq_lim = 15; deq_lim = 75; end
        default: begin enq_lim = 40; deq_lim = 78; end
      endcase
      for (int k = 0; k < len; k++) begin
        r   = $urandom_range(0, 99);
        v   = $urandom_range(0, 1) ? byte_t'($urandom_range(0, 255))
                                   : byte_t'($urandom_range(0, 7));
        gap = quiet ? 0 : $urandom_range(0, 8);
        add_req(r < enq_lim ? REQ_ENQ : r < deq_lim ? REQ_DEQ : r < 97 ? REQ_FIND : REQ_NOP,
                v, gap, (req_queue.size() % 200 == 199));
      end
    end

    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while ((req_queue.size() != 0 || in_tvalid || reply_queue.size() != 0) &&
           cycles < CYC_LIMIT)
      @(posedge clk);

    if (cycles >= CYC_LIMIT) begin
      $display("[byte_ring_fifo_with_search] ERROR");
    end else begin
      repeat (40) @(posedge clk);
      $display("covered %0d requests: %0d enqueued, %0d dropped when full, %0d dequeued,",
               items_sent, n_enq_ok, n_enq_drop, n_deq_ok);
      $display("%0d empty dequeues, %0d search hits, %0d misses, %0d unused codes; %0d mismatches",
               n_deq_empty, n_find_hit, n_find_miss, n_nop, mismatches);
      if (mismatches == 0 && reply_queue.size() == 0) begin
        $display("[byte_ring_fifo_with_search] OK");
      end else begin
        $display("[byte_ring_fifo_with_search] ERROR");
      end
    end
    $finish;
  end

endmodule

// ===== byte_ring_fifo_with_search.f =====
rtl/brfs_pkg.sv
rtl/brfs_ram.sv
rtl/byte_ring_fifo_with_search.sv
sim/byte_ring_fifo_with_search_tb.sv
